FILE: rtl/ring_fifo_xon_xoff_defines.svh
// ----------------------------------------------------------------------------
// ring_fifo_xon_xoff assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RING_FIFO_XON_XOFF_DEFINES_SVH
`define RING_FIFO_XON_XOFF_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RFX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfx check failed");

// next-cycle implication, disabled in reset
`define RFX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rfx check failed");

`endif

FILE: rtl/rfx_pkg.sv
// ----------------------------------------------------------------------------
// rfx_pkg
// types and constants of the ring fifo with xon/xoff flow control
// ----------------------------------------------------------------------------
`default_nettype none

package rfx_pkg;

  localparam int BYTE_W    = 8;
  localparam int ERR_W     = 2;
  localparam int LVL_W     = 8;
  localparam int THR_W     = 8;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [0:0] {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  localparam logic [CFG_IDX_W-1:0] CFG_XOFF_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XON_THR  = 1'd1;

  localparam logic [THR_W-1:0] RST_XOFF_THR = 8'd10;
  localparam logic [THR_W-1:0] RST_XON_THR  = 8'd20;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
  } rfx_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rfx_req_if.sv
// ----------------------------------------------------------------------------
// rfx_req_if
// request channel: one push or pop command per transfer
// ----------------------------------------------------------------------------
`default_nettype none

interface rfx_req_if import rfx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] push_byte;

  modport source (output valid, output command, output push_byte, input ready);
  modport sink   (input valid, input command, input push_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/rfx_rsp_if.sv
// ----------------------------------------------------------------------------
// rfx_rsp_if
// response channel: one result per command
// ----------------------------------------------------------------------------
`default_nettype none

interface rfx_rsp_if import rfx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pop_byte;
  logic [ERR_W-1:0]  error_code;
  logic              xoff_active;
  logic [LVL_W-1:0]  fill_level;

  modport source (output valid, output pop_byte, output error_code,
                  output xoff_active, output fill_level, input ready);
  modport sink   (input valid, input pop_byte, input error_code,
                  input xoff_active, input fill_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/rfx_ctrl.sv
// ----------------------------------------------------------------------------
// rfx_ctrl
// sequencing of command intake, byte store read and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rfx_ctrl import rfx_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     out_ready_i,
  output logic          out_valid_o,
  output rfx_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, load;

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign load   = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;

endmodule

`default_nettype wire

FILE: rtl/rfx_dp.sv
// ----------------------------------------------------------------------------
// rfx_dp
// byte store, pointers, fill count, xoff hysteresis and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rfx_dp import rfx_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rfx_cmd_t             cmd_i,
  input  wire logic                 command_i,
  input  wire logic [BYTE_W-1:0]    push_byte_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [THR_W-1:0]     cfg_data_i,
  output logic [BYTE_W-1:0]         pop_byte_o,
  output logic [ERR_W-1:0]          error_code_o,
  output logic                      xoff_active_o,
  output logic [LVL_W-1:0]          fill_level_o
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > THR_W) ? CW : THR_W;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_q;

  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             flag_q, flag_d;
  err_e             err_q, err_d;
  logic             pop_ok_q;
  logic [THR_W-1:0] xoff_thr_q, xon_thr_q;

  logic [BYTE_W-1:0] pop_byte_q;
  err_e              error_q;
  logic              xoff_q;
  logic [LVL_W-1:0]  level_q;

  logic          is_pop, full, empty, push_ok, pop_ok;
  logic [CW-1:0] free_space;

  assign is_pop  = (command_i == CMD_POP);
  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign push_ok = !is_pop && !full;
  assign pop_ok  = is_pop && !empty;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    err_d    = ERR_OK;
    if (push_ok) begin
      wr_ptr_d = advance(wr_ptr_q);
      count_d  = count_q + 1'b1;
    end else if (pop_ok) begin
      rd_ptr_d = advance(rd_ptr_q);
      count_d  = count_q - 1'b1;
    end else if (is_pop) begin
      err_d = ERR_EMPTY;
    end else begin
      err_d = ERR_FULL;
    end
  end

  // xoff test wins when both thresholds match
  assign free_space = CW'(DEPTH) - count_d;

  always_comb begin
    flag_d = flag_q;
    priority if (CMPW'(free_space) <= CMPW'(xoff_thr_q)) begin
      flag_d = 1'b1;
    end else if (CMPW'(free_space) >= CMPW'(xon_thr_q)) begin
      flag_d = 1'b0;
    end else begin
      flag_d = flag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && push_ok) begin
      mem[wr_ptr_q] <= push_byte_i;
    end
    if (cmd_i.accept && pop_ok) begin
      rd_data_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      count_q    <= '0;
      flag_q     <= 1'b0;
      err_q      <= ERR_OK;
      pop_ok_q   <= 1'b0;
      xoff_thr_q <= RST_XOFF_THR;
      xon_thr_q  <= RST_XON_THR;
    end else begin
      if (cmd_i.accept) begin
        rd_ptr_q <= rd_ptr_d;
        wr_ptr_q <= wr_ptr_d;
        count_q  <= count_d;
        flag_q   <= flag_d;
        err_q    <= err_d;
        pop_ok_q <= pop_ok;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_XOFF_THR: xoff_thr_q <= cfg_data_i;
          CFG_XON_THR:  xon_thr_q  <= cfg_data_i;
          default:      xon_thr_q  <= xon_thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pop_byte_q <= pop_ok_q ? rd_data_q : '0;
      error_q    <= err_q;
      xoff_q     <= flag_q;
      level_q    <= LVL_W'(count_q);
    end
  end

  assign pop_byte_o    = pop_byte_q;
  assign error_code_o  = error_q;
  assign xoff_active_o = xoff_q;
  assign fill_level_o  = level_q;

endmodule

`default_nettype wire

FILE: rtl/ring_fifo_xon_xoff.sv
// ----------------------------------------------------------------------------
// ring_fifo_xon_xoff
// receive byte fifo with xon/xoff flow control flag
// ----------------------------------------------------------------------------
// Each request is a push or a pop and yields exactly one response carrying
// the popped byte (zero unless a pop succeeded), an error code (push to a
// full fifo, pop from an empty one; neither changes the contents), the
// xoff flag after the command and the fill level (modulo 256). The flag
// sets when free space drops to the xoff threshold or below and clears
// when it reaches the xon threshold or above. A command is first accepted,
// which updates the pointers and does the registered read of the
// single-port byte store, and is then loaded into the response register
// once that register is free; no new request is taken before that load.
// Thresholds may be written only while no command is outstanding.
`default_nettype none

module ring_fifo_xon_xoff import rfx_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  rfx_req_if.sink                   req_i,
  rfx_rsp_if.source                 rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [THR_W-1:0]     cfg_data_i
);

  rfx_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;

  rfx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  rfx_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (req_i.command),
    .push_byte_i   (req_i.push_byte),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .pop_byte_o    (rsp_o.pop_byte),
    .error_code_o  (rsp_o.error_code),
    .xoff_active_o (rsp_o.xoff_active),
    .fill_level_o  (rsp_o.fill_level)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

endmodule

`default_nettype wire

FILE: rtl/rfx_checker.sv
// ----------------------------------------------------------------------------
// rfx_checker
// port-level checks of the ring fifo, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "ring_fifo_xon_xoff_defines.svh"

module rfx_checker import rfx_pkg::*; #(
  parameter int DEPTH = 128
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] pop_byte,
  input wire logic [ERR_W-1:0]  error_code,
  input wire logic [LVL_W-1:0]  fill_level
);

  // one command in flight
  `RFX_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // a refused push only happens at full level
  `RFX_ASSERT_SAME(a_full_level, out_valid && (error_code == ERR_FULL), fill_level == LVL_W'(DEPTH))
  // a refused pop reports an empty fifo and a zero byte
  `RFX_ASSERT_SAME(a_empty_pop, out_valid && (error_code == ERR_EMPTY), (fill_level == '0) && (pop_byte == '0))
  // no code beyond the defined errors
  `RFX_ASSERT_SAME(a_err_code, out_valid, (error_code == ERR_OK) || (error_code == ERR_FULL) || (error_code == ERR_EMPTY))
  // a stalled response holds
  `RFX_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(pop_byte) && $stable(error_code) && $stable(fill_level))

endmodule

bind ring_fifo_xon_xoff rfx_checker #(
  .DEPTH (DEPTH)
) u_rfx_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .pop_byte   (rsp_o.pop_byte),
  .error_code (rsp_o.error_code),
  .fill_level (rsp_o.fill_level)
);

`default_nettype wire
